// ----- rtl/core/tps_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_pkg
// Shared widths, codes and the command/status types of the trace pair
// similarity unit.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_PAIRS   = 4096;
  localparam int CNT_W       = $clog2(MAX_PAIRS + 1);

  // Accumulator widths.
  localparam int EA_W = 44;
  localparam int CS_W = 45;
  localparam int DE_W = 46;

  // Sequential multiplier: 44-bit operands taken in two 22-bit digits.
  localparam int MUL_W   = 44;
  localparam int MUL_DIG = 22;
  localparam int PP_W    = MUL_W + MUL_DIG;
  localparam int PROD_W  = 2 * MUL_W;

  // Restoring divider.
  localparam int FRAC_BITS = 32;
  localparam int DIV_N     = PROD_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_N);
  localparam int QUOT_W    = 40;

  // Digit-by-digit square root.
  localparam int SQ_IN_W   = 46;
  localparam int SQ_STEPS  = SQ_IN_W / 2;
  localparam int SQ_ROOT_W = SQ_STEPS;
  localparam int SQ_REM_W  = SQ_ROOT_W + 2;
  localparam int SQ_SH_W   = SQ_REM_W + 2;
  localparam int SQ_CNT_W  = $clog2(SQ_STEPS);

  localparam int Q15_ONE = 32768;
  localparam int Q15_MAX = 32767;

  typedef enum logic {
    MODE_CORR = 1'b0,
    MODE_DIST = 1'b1
  } tps_mode_e;

  typedef enum logic {
    MUL_ENERGY = 1'b0,
    MUL_CROSS  = 1'b1
  } tps_mul_sel_e;

  typedef enum logic {
    DIV_CORR = 1'b0,
    DIV_DIST = 1'b1
  } tps_div_sel_e;

  typedef enum logic [1:0] {
    SQ_EA = 2'd0,
    SQ_EB = 2'd1,
    SQ_DE = 2'd2,
    SQ_QT = 2'd3
  } tps_sq_sel_e;

  typedef enum logic [3:0] {
    S_RUN,
    S_DRAIN,
    S_CHECK,
    S_MUL_P,
    S_MUL_C,
    S_DIV,
    S_SQRT_C,
    S_SQRT_A,
    S_SQRT_B,
    S_SQRT_D,
    S_RESULT
  } tps_state_e;

  typedef struct packed {
    logic         accept;
    logic         mul_start;
    tps_mul_sel_e mul_sel;
    logic         div_start;
    tps_div_sel_e div_sel;
    logic         sq_start;
    tps_sq_sel_e  sq_sel;
    logic         load_out;
  } tps_cmd_t;

  typedef struct packed {
    logic      undef;
    tps_mode_e mode;
    logic      busy;
    logic      out_free;
  } tps_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/tps_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_ctrl
// Sequencer: streams a gate into the accumulators, then runs the multiply,
// divide and root steps of the selected measure and hands off the result.
// ----------------------------------------------------------------------------
module tps_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  input  wire tps_pkg::tps_stat_t stat_i,
  output tps_pkg::tps_cmd_t      cmd_o
);
  import tps_pkg::*;

  tps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_RUN;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_RUN: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = S_DRAIN;
        end
      end
      // The last product is still in the pipeline register here.
      S_DRAIN: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.undef) begin
          state_d = S_RESULT;
        end else if (stat_i.mode == MODE_CORR) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_ENERGY;
          state_d         = S_MUL_P;
        end else begin
          cmd_o.sq_start = 1'b1;
          cmd_o.sq_sel   = SQ_EA;
          state_d        = S_SQRT_A;
        end
      end
      S_MUL_P: begin
        if (!stat_i.busy) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_CROSS;
          state_d         = S_MUL_C;
        end
      end
      S_MUL_C: begin
        if (!stat_i.busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_CORR;
          state_d         = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat_i.busy) begin
          if (stat_i.mode == MODE_CORR) begin
            cmd_o.sq_start = 1'b1;
            cmd_o.sq_sel   = SQ_QT;
            state_d        = S_SQRT_C;
          end else begin
            state_d = S_RESULT;
          end
        end
      end
      S_SQRT_C: begin
        if (!stat_i.busy) begin
          state_d = S_RESULT;
        end
      end
      S_SQRT_A: begin
        if (!stat_i.busy) begin
          cmd_o.sq_start = 1'b1;
          cmd_o.sq_sel   = SQ_EB;
          state_d        = S_SQRT_B;
        end
      end
      S_SQRT_B: begin
        if (!stat_i.busy) begin
          cmd_o.sq_start = 1'b1;
          cmd_o.sq_sel   = SQ_DE;
          state_d        = S_SQRT_D;
        end
      end
      S_SQRT_D: begin
        if (!stat_i.busy) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_DIST;
          state_d         = S_DIV;
        end
      end
      S_RESULT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_RUN;
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/tps_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tps_dp
// Datapath: product pipeline and accumulators, a two-digit sequential
// multiplier, a restoring divider, a digit-by-digit square root and the
// output register.
// ----------------------------------------------------------------------------
module tps_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tps_pkg::tps_cmd_t cmd_i,
  output tps_pkg::tps_stat_t     stat_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic [31:0]       in_data_i,
  input  wire logic [1:0]        in_user_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            out_data_o,
  output logic                   out_user_o
);
  import tps_pkg::*;

  // ---------------- configuration ----------------
  tps_mode_e mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_CORR;
    end else if (cfg_we_i) begin
      mode_q <= tps_mode_e'(cfg_wdata_i);
    end
  end

  // ---------------- product stage ----------------
  logic signed [SAMPLE_BITS-1:0] smp_a, smp_b;
  logic signed [SAMPLE_BITS:0]   smp_d;
  logic signed [2*SAMPLE_BITS-1:0] sq_aa, sq_bb, sq_ab;
  logic signed [2*SAMPLE_BITS+1:0] sq_dd;
  logic [CNT_W-1:0] cnt_q;
  logic             use_pair;

  assign smp_a = signed'(in_data_i[SAMPLE_BITS-1:0]);
  assign smp_b = signed'(in_data_i[2*SAMPLE_BITS-1:SAMPLE_BITS]);
  assign smp_d = (SAMPLE_BITS+1)'(smp_a) - (SAMPLE_BITS+1)'(smp_b);
  assign sq_aa = smp_a * smp_a;
  assign sq_bb = smp_b * smp_b;
  assign sq_ab = smp_a * smp_b;
  assign sq_dd = smp_d * smp_d;
  assign use_pair = cmd_i.accept && in_user_i[0] && in_user_i[1] &&
                    (cnt_q < CNT_W'(MAX_PAIRS));

  logic                          pv_q;
  logic [2*SAMPLE_BITS-1:0]      paa_q, pbb_q;
  logic signed [2*SAMPLE_BITS-1:0] pab_q;
  logic [2*SAMPLE_BITS+1:0]      pdd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else begin
      pv_q <= use_pair;
    end
  end

  always_ff @(posedge clk_i) begin
    if (use_pair) begin
      paa_q <= sq_aa;
      pbb_q <= sq_bb;
      pab_q <= sq_ab;
      pdd_q <= sq_dd;
    end
  end

  // ---------------- accumulators ----------------
  logic [EA_W-1:0]        ea_q, eb_q;
  logic signed [CS_W-1:0] cs_q;
  logic [DE_W-1:0]        de_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ea_q  <= '0;
      eb_q  <= '0;
      cs_q  <= '0;
      de_q  <= '0;
      cnt_q <= '0;
    end else if (cmd_i.load_out) begin
      ea_q  <= '0;
      eb_q  <= '0;
      cs_q  <= '0;
      de_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (use_pair) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (pv_q) begin
        ea_q <= ea_q + EA_W'(paa_q);
        eb_q <= eb_q + EA_W'(pbb_q);
        cs_q <= cs_q + CS_W'(pab_q);
        de_q <= de_q + DE_W'(pdd_q);
      end
    end
  end

  logic            undef;
  logic            cs_neg;
  logic [CS_W-1:0] cs_mag;

  assign undef  = (cnt_q == '0) || (ea_q == '0) || (eb_q == '0);
  assign cs_neg = cs_q[CS_W-1];
  assign cs_mag = cs_neg ? CS_W'(-cs_q) : CS_W'(cs_q);

  // ---------------- sequential multiplier ----------------
  logic              mul_busy_q;
  logic [1:0]        mul_cnt_q;
  tps_mul_sel_e      mul_sel_q;
  logic [MUL_W-1:0]  mop_a_q, mop_b_q;
  logic [MUL_DIG-1:0] mul_digit;
  logic [PP_W-1:0]   mul_pp, pp_q;
  logic [PROD_W-1:0] macc_q, mul_res;
  logic [PROD_W-1:0] prod_p_q, csq_q;

  assign mul_digit = (mul_cnt_q == 2'd0) ? mop_b_q[MUL_DIG-1:0]
                                         : mop_b_q[MUL_W-1:MUL_DIG];
  assign mul_pp    = PP_W'(mop_a_q) * PP_W'(mul_digit);
  assign mul_res   = macc_q + (PROD_W'(pp_q) << MUL_DIG);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_busy_q <= 1'b0;
      mul_cnt_q  <= '0;
    end else if (cmd_i.mul_start) begin
      mul_busy_q <= 1'b1;
      mul_cnt_q  <= '0;
    end else if (mul_busy_q) begin
      mul_cnt_q <= mul_cnt_q + 2'd1;
      if (mul_cnt_q == 2'd2) begin
        mul_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_start) begin
      mul_sel_q <= cmd_i.mul_sel;
      if (cmd_i.mul_sel == MUL_ENERGY) begin
        mop_a_q <= ea_q;
        mop_b_q <= eb_q;
      end else begin
        mop_a_q <= MUL_W'(cs_mag);
        mop_b_q <= MUL_W'(cs_mag);
      end
    end else if (mul_busy_q) begin
      pp_q <= mul_pp;
      if (mul_cnt_q == 2'd1) begin
        macc_q <= PROD_W'(pp_q);
      end
      if (mul_cnt_q == 2'd2) begin
        if (mul_sel_q == MUL_ENERGY) begin
          prod_p_q <= mul_res;
        end else begin
          csq_q <= mul_res;
        end
      end
    end
  end

  // ---------------- square root ----------------
  logic                 sq_busy_q;
  logic [SQ_CNT_W-1:0]  sq_cnt_q;
  tps_sq_sel_e          sq_sel_q;
  logic [SQ_IN_W-1:0]   sq_v_q;
  logic [SQ_REM_W-1:0]  sq_rem_q;
  logic [SQ_ROOT_W-1:0] sq_root_q, sq_root_n;
  logic [SQ_SH_W-1:0]   sq_sh, sq_trial;
  logic                 sq_ge;
  logic [SQ_ROOT_W-1:0] sa_q, sb_q, sd_q, sc_q;
  logic [QUOT_W-1:0]    quot_q;

  assign sq_sh     = {sq_rem_q, sq_v_q[SQ_IN_W-1 -: 2]};
  assign sq_trial  = SQ_SH_W'({sq_root_q, 2'b01});
  assign sq_ge     = (sq_sh >= sq_trial);
  assign sq_root_n = {sq_root_q[SQ_ROOT_W-2:0], sq_ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
      sq_cnt_q  <= '0;
    end else if (cmd_i.sq_start) begin
      sq_busy_q <= 1'b1;
      sq_cnt_q  <= '0;
    end else if (sq_busy_q) begin
      sq_cnt_q <= sq_cnt_q + SQ_CNT_W'(1);
      if (sq_cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
        sq_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_start) begin
      sq_sel_q  <= cmd_i.sq_sel;
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      case (cmd_i.sq_sel)
        SQ_EA:   sq_v_q <= SQ_IN_W'(ea_q);
        SQ_EB:   sq_v_q <= SQ_IN_W'(eb_q);
        SQ_DE:   sq_v_q <= SQ_IN_W'(de_q);
        SQ_QT:   sq_v_q <= SQ_IN_W'(quot_q);
        default: sq_v_q <= '0;
      endcase
    end else if (sq_busy_q) begin
      sq_v_q    <= sq_v_q << 2;
      sq_rem_q  <= sq_ge ? SQ_REM_W'(sq_sh - sq_trial) : SQ_REM_W'(sq_sh);
      sq_root_q <= sq_root_n;
      if (sq_cnt_q == SQ_CNT_W'(SQ_STEPS - 1)) begin
        case (sq_sel_q)
          SQ_EA:   sa_q <= sq_root_n;
          SQ_EB:   sb_q <= sq_root_n;
          SQ_DE:   sd_q <= sq_root_n;
          SQ_QT:   sc_q <= sq_root_n;
          default: sc_q <= sq_root_n;
        endcase
      end
    end
  end

  // ---------------- restoring divider ----------------
  logic                 div_busy_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [DIV_N-1:0]     dvd_q;
  logic [PROD_W-1:0]    dvs_q, rem_q;
  logic [PROD_W:0]      div_sh;
  logic                 div_ge;
  logic [SQ_ROOT_W:0]   den;
  logic [QUOT_W-1:0]    dist_num;

  assign den      = (SQ_ROOT_W+1)'(sa_q) + (SQ_ROOT_W+1)'(sb_q);
  assign dist_num = (QUOT_W'(sd_q) << 16) + QUOT_W'(den);
  assign div_sh   = {rem_q, dvd_q[DIV_N-1]};
  assign div_ge   = (div_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
      if (div_cnt_q == DIV_CNT_W'(DIV_N - 1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q  <= '0;
      quot_q <= '0;
      if (cmd_i.div_sel == DIV_CORR) begin
        // Quotient is floor(cross^2 * 2^32 / (Ea * Eb)).
        dvd_q <= {csq_q, FRAC_BITS'(0)};
        dvs_q <= prod_p_q;
      end else begin
        dvd_q <= DIV_N'(dist_num);
        dvs_q <= PROD_W'({den, 1'b0});
      end
    end else if (div_busy_q) begin
      dvd_q  <= dvd_q << 1;
      rem_q  <= div_ge ? PROD_W'(div_sh - {1'b0, dvs_q}) : PROD_W'(div_sh);
      quot_q <= {quot_q[QUOT_W-2:0], div_ge};
    end
  end

  // ---------------- result formatting ----------------
  logic [SQ_ROOT_W:0]   sc_inc;
  logic [SQ_ROOT_W-1:0] q_corr;
  logic [16:0]          q_corr_neg;
  logic [16:0]          q_dist;
  logic signed [17:0]   r_dist;
  logic [15:0]          sim_corr, sim_dist, sim;

  // Largest odd k with k*k at or below the quotient gives q = (k+1)/2.
  assign sc_inc     = (SQ_ROOT_W+1)'(sc_q) + (SQ_ROOT_W+1)'(1);
  assign q_corr     = sc_inc[SQ_ROOT_W:1];
  assign q_corr_neg = 17'(0) - 17'(q_corr);
  assign sim_corr   = cs_neg ? q_corr_neg[15:0] :
                      ((q_corr > SQ_ROOT_W'(Q15_MAX)) ? 16'(Q15_MAX) : q_corr[15:0]);

  assign q_dist   = (quot_q > QUOT_W'(2 * Q15_ONE)) ? 17'(2 * Q15_ONE) : 17'(quot_q);
  assign r_dist   = 18'(Q15_ONE) - signed'({1'b0, q_dist});
  assign sim_dist = (r_dist > 18'(Q15_MAX)) ? 16'(Q15_MAX) : r_dist[15:0];

  assign sim = undef ? 16'd0 : ((mode_q == MODE_CORR) ? sim_corr : sim_dist);

  logic        out_valid_q;
  logic [15:0] out_sim_q;
  logic        out_stat_q;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_sim_q  <= sim;
      out_stat_q <= undef;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_sim_q;
  assign out_user_o  = out_stat_q;

  assign stat_o.undef    = undef;
  assign stat_o.mode     = mode_q;
  assign stat_o.busy     = mul_busy_q || div_busy_q || sq_busy_q;
  assign stat_o.out_free = out_free;

  // ---------------- assertions ----------------
  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({mul_busy_q, div_busy_q, sq_busy_q}))
    else $error("more than one arithmetic unit busy");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_PAIRS))
    else $error("pair count beyond limit");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.accept |-> !(mul_busy_q || div_busy_q || sq_busy_q))
    else $error("beat accepted while a unit is busy");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites a pending beat");

endmodule
`default_nettype wire

// ----- rtl/core/trace_pair_similarity_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trace_pair_similarity_unit
// Correlation or distance similarity of two aligned traces over one gate.
// ----------------------------------------------------------------------------
// Sample pairs stream in at one beat per cycle; pairs with either valid flag
// low are skipped and pairs beyond 4096 per gate are ignored. After the beat
// with tlast, input is held off while the result is computed on one shared
// 44x22 multiplier, a one-bit-per-cycle 120-step divider and a two-bit-per-
// cycle 23-step square root: two products, divide and root in correlation
// mode, three roots and divide in distance mode, and then for as long as a
// previous result still waits on the output. A gate with no used pair or a
// zero energy gives status 1 and skips the arithmetic.
// ----------------------------------------------------------------------------
module trace_pair_similarity_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,     // measure_mode
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,  // sample_a, sample_b
  input  wire logic [1:0]  s_axis_tuser_i,  // valid_a, valid_b
  input  wire logic        s_axis_tlast_i,  // last_pair
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // similarity
  output logic             m_axis_tuser_o   // status
);
  import tps_pkg::*;

  tps_cmd_t  cmd;
  tps_stat_t stat;

  tps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  tps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

// ----- test/trace_pair_similarity_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trace_pair_similarity_unit_tb
// Self-checking bench for the trace pair similarity unit. Gates of sample
// pairs are streamed in under random idling on both sides. An in-bench model
// of the accumulators, the correlation and the distance measure predicts
// every result, which is compared field by field with the output beats.
// ----------------------------------------------------------------------------
module trace_pair_similarity_unit_tb;
  import tps_pkg::*;

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE       = 250;

  typedef struct packed {
    logic [15:0] sim;
    logic        undef;
  } gate_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        s_axis_tlast_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  trace_pair_similarity_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Model state of the gate accumulators.
  tps_mode_e       mode_q = MODE_CORR;
  logic [63:0]     sum_aa, sum_bb, sum_dd;
  logic signed [63:0] sum_ab;
  int unsigned     used_pairs;

  gate_result_t    pending_results[$];
  int              errors = 0;
  int unsigned     cycles = 0;
  bit              send_idle = 1'b1;
  bit              recv_idle = 1'b1;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] res, bitv, x;
    res = 0;
    x = v;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] corr_coeff();
    logic [159:0] prod, rhs, lhs;
    logic [63:0]  mag;
    logic [63:0]  k;
    int unsigned  lo, hi, mid;
    bit           neg;
    neg = sum_ab < 0;
    mag = neg ? 64'(-sum_ab) : 64'(sum_ab);
    prod = 160'(sum_aa) * 160'(sum_bb);
    rhs = (160'(mag) * 160'(mag)) << 32;
    lo = 0;
    hi = 32768;
    // Largest q whose half-step bound still fits: |r| rounded half away.
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * 64'(mid) - 1;
      lhs = 160'(k * k) * prod;
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    if (neg) return 16'(-int'(lo));
    return (lo > Q15_MAX) ? 16'(Q15_MAX) : 16'(lo);
  endfunction

  function automatic logic [15:0] dist_sim();
    logic [63:0] sa, sb, sd, den, q;
    longint      r;
    sa = root_floor(sum_aa);
    sb = root_floor(sum_bb);
    sd = root_floor(sum_dd);
    den = sa + sb;
    q = (sd * 65536 + den) / (2 * den);
    if (q > 65536) q = 65536;
    r = 32768 - longint'(q);
    if (r > Q15_MAX) r = Q15_MAX;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic void clear_gate();
    sum_aa = 0;
    sum_bb = 0;
    sum_dd = 0;
    sum_ab = 0;
    used_pairs = 0;
  endfunction

  function automatic void absorb_pair(input logic signed [15:0] a, input logic signed [15:0] b,
                                      input logic va, input logic vb, input logic last);
    longint       la, lb, ld;
    gate_result_t res;
    la = a;
    lb = b;
    ld = la - lb;
    if (va && vb && used_pairs < MAX_PAIRS) begin
      sum_aa += 64'(la * la);
      sum_bb += 64'(lb * lb);
      sum_dd += 64'(ld * ld);
      sum_ab += la * lb;
      used_pairs++;
    end
    if (last) begin
      res.sim = '0;
      res.undef = 1'b1;
      if (used_pairs != 0 && sum_aa != 0 && sum_bb != 0) begin
        res.sim = (mode_q == MODE_CORR) ? corr_coeff() : dist_sim();
        res.undef = 1'b0;
      end
      pending_results.push_back(res);
      clear_gate();
    end
  endfunction

  // Called at a rising edge; leaves tvalid high after the accepting edge.
  task automatic send_pair(input logic [15:0] a, input logic [15:0] b,
                           input logic va, input logic vb, input logic last);
    int gap;
    gap = send_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {b, a};
    s_axis_tuser_i  <= {vb, va};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_pair(a, b, va, vb, last);
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mode(input tps_mode_e m);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
    @(posedge clk_i);
  endtask

  // Directed gates covering the corner cases of one measure.
  task automatic test_directed(input tps_mode_e m);
    write_mode(m);
    send_pair(16'h1234, 16'h0042, 1'b0, 1'b1, 1'b1);   // nothing used
    send_pair(16'h0000, 16'h0100, 1'b1, 1'b1, 1'b1);   // zero energy on a
    send_pair(16'h0100, 16'h0000, 1'b1, 1'b1, 1'b1);   // zero energy on b
    send_pair(16'h8000, 16'h8000, 1'b1, 1'b1, 1'b0);   // identical extremes
    send_pair(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 1'b1);
    send_pair(16'h8000, 16'h7FFF, 1'b1, 1'b1, 1'b0);   // opposite extremes
    send_pair(16'h7FFF, 16'h8001, 1'b1, 1'b1, 1'b1);
    send_pair(16'h0003, 16'hFFFD, 1'b1, 1'b1, 1'b0);
    send_pair(16'h7FFF, 16'h0005, 1'b1, 1'b0, 1'b0);   // skipped pair
    send_pair(16'h0001, 16'h0002, 1'b0, 1'b0, 1'b1);   // skipped on last
    send_pair(16'h0001, 16'h0000, 1'b1, 1'b1, 1'b0);
    send_pair(16'h0000, 16'h0001, 1'b1, 1'b1, 1'b1);   // orthogonal
  endtask

  task automatic test_random_gates(input int n_items);
    int sent, len, kind;
    logic [15:0] a, b;
    logic va, vb;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      kind = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) send_idle = ~send_idle;
      if ($urandom_range(0, 3) == 0) recv_idle = ~recv_idle;
      for (int i = 0; i < len; i++) begin
        a = 16'($urandom);
        case (kind)
          0: b = a;
          1: b = -a;
          2: b = a + 16'($signed($urandom_range(0, 64)) - 32);
          3: begin
            a = 16'($signed($urandom_range(0, 200)) - 100);
            b = 16'($signed($urandom_range(0, 200)) - 100);
          end
          4: b = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
          default: b = 16'($urandom);
        endcase
        va = $urandom_range(0, 15) != 0;
        vb = $urandom_range(0, 15) != 0;
        send_pair(a, b, va, vb, i == len - 1);
        sent++;
      end
    end
  endtask

  // Result side: random stalls, checked against the oldest prediction.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 11) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    gate_result_t exp_res;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        report("result beat with no gate pending");
      end else begin
        exp_res = pending_results.pop_front();
        if (m_axis_tdata_o !== exp_res.sim)
          report($sformatf("similarity %0d, expected %0d", $signed(m_axis_tdata_o),
                           $signed(exp_res.sim)));
        if (m_axis_tuser_o !== exp_res.undef)
          report($sformatf("status %0b, expected %0b", m_axis_tuser_o, exp_res.undef));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("trace_pair_similarity_unit: mismatch");
      $finish;
    end
  end

  initial begin
    clear_gate();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Reset mode is correlation; try it before any register write.
    send_pair(16'h0400, 16'h0200, 1'b1, 1'b1, 1'b0);
    send_pair(16'hFC00, 16'hFE10, 1'b1, 1'b1, 1'b1);
    test_directed(MODE_CORR);
    test_directed(MODE_DIST);
    write_mode(MODE_CORR);
    test_random_gates(450);
    // Hold the stream until every result is back, then resume.
    wait_drained();
    test_random_gates(400);
    write_mode(MODE_DIST);
    test_random_gates(450);
    write_mode(MODE_CORR);
    test_random_gates(200);
    write_mode(MODE_DIST);
    test_random_gates(200);
    wait_drained();
    if (errors == 0) begin
      $display("trace_pair_similarity_unit: match");
    end else begin
      $display("trace_pair_similarity_unit: mismatch");
    end
    $finish;
  end

endmodule
